FILE: sv/gscl_pkg.sv
// Package for the gradient stop color lookup unit.
// Holds widths, register codes, reset values and the pipeline depth; no dependencies.
package gscl_pkg;

  localparam int BAND_BITS = 10;
  localparam int TOT_W = BAND_BITS + 1;
  localparam int POS_W = 16;
  localparam int COLOR_W = 32;
  localparam int STOP_W = POS_W + COLOR_W;
  localparam int MAX_STOPS = 7;
  localparam int COUNT_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_W = 17;
  localparam int DIV_STEPS = 4;
  localparam int NSTAGE = 16;

  localparam logic [POS_W-1:0] ONE_Q15 = 16'd32768;
  localparam logic [COUNT_W-1:0] MIN_COUNT = 3'd2;
  localparam logic [POS_W-1:0] NARROW_SPAN = 16'd3;

  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;

  localparam logic [COUNT_W-1:0] RST_COUNT = 3'd4;
  localparam logic [STOP_W-1:0] RST_STOPS [MAX_STOPS] = '{
    48'd4279913471, 48'd42223812420351, 48'd91480846563071,
    48'd140737499103231, 48'd0, 48'd0, 48'd0
  };

endpackage

FILE: sv/gscl_if.sv
// Handshake interfaces for the request and response channels.
// Depends on gscl_pkg for field widths.
interface gscl_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic [gscl_pkg::POS_W-1:0] position;
  logic [gscl_pkg::BAND_BITS-1:0] band_num;
  logic [gscl_pkg::TOT_W-1:0] band_total;
  modport source (output valid, kind, position, band_num, band_total, input ready);
  modport sink (input valid, kind, position, band_num, band_total, output ready);
endinterface

interface gscl_out_if;
  logic valid;
  logic ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

FILE: sv/gscl_div_step.sv
// Several restoring division steps, one quotient bit each.
// Depends on gscl_pkg for the datapath width and the step count.
module gscl_div_step (
  input  logic [gscl_pkg::DIV_W-1:0] rem_in,
  input  logic [gscl_pkg::DIV_W-1:0] divisor,
  input  logic [gscl_pkg::DIV_W-1:0] quo_in,
  output logic [gscl_pkg::DIV_W-1:0] rem_out,
  output logic [gscl_pkg::DIV_W-1:0] quo_out
);

  logic [gscl_pkg::DIV_W:0] r;
  logic [gscl_pkg::DIV_W-1:0] q;

  always_comb begin
    r = {1'b0, rem_in};
    q = quo_in;
    for (int i = 0; i < gscl_pkg::DIV_STEPS; i++) begin
      r = {r[gscl_pkg::DIV_W-1:0], 1'b0};
      if (r >= {1'b0, divisor}) begin
        r = r - {1'b0, divisor};
        q = {q[gscl_pkg::DIV_W-2:0], 1'b1};
      end else begin
        q = {q[gscl_pkg::DIV_W-2:0], 1'b0};
      end
    end
    rem_out = r[gscl_pkg::DIV_W-1:0];
    quo_out = q;
  end

endmodule

FILE: sv/gradient_stop_color_lookup_unit.sv
// Top level of the gradient stop color lookup unit: config registers and pipeline.
// Depends on gscl_pkg, gscl_if and gscl_div_step.
//
//   channel | direction | payload
//   req     | in        | kind, position, band_num, band_total
//   rsp     | out       | red, green, blue, alpha
//   cfg     | in        | cfg_we, cfg_index, cfg_data (write only)
//
// One transaction enters per cycle unless a result waits on rsp; each result is presented
// on rsp after its request passes through 16 register stages.
// The two long divisions take four quotient bits per stage, five in the first stage of the second.
// The whole pipeline advances together and holds while a result waits on rsp.
// Reset is synchronous and restores the default four-stop palette.
module gradient_stop_color_lookup_unit (
  input  logic clk,
  input  logic rst,
  gscl_in_if.sink req,
  gscl_out_if.source rsp,
  input  logic cfg_we,
  input  logic [gscl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gscl_pkg::STOP_W-1:0] cfg_data
);

  localparam int DW = gscl_pkg::DIV_W;
  localparam int PW = gscl_pkg::POS_W;
  localparam int CW = gscl_pkg::COLOR_W;

  logic [gscl_pkg::COUNT_W-1:0] stop_count;
  logic [gscl_pkg::STOP_W-1:0] stops [gscl_pkg::MAX_STOPS];
  logic [gscl_pkg::NSTAGE-1:0] vld;
  logic en;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= gscl_pkg::RST_COUNT;
      stops <= gscl_pkg::RST_STOPS;
    end else if (cfg_we) begin
      if (cfg_index == gscl_pkg::REG_STOP_COUNT) begin
        stop_count <= cfg_data[gscl_pkg::COUNT_W-1:0];
      end else begin
        stops[gscl_pkg::CFG_IDX_W'(cfg_index - 1'b1)] <= cfg_data;
      end
    end
  end

  assign en = !vld[gscl_pkg::NSTAGE-1] || rsp.ready;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[gscl_pkg::NSTAGE-2:0], req.valid};
    end
  end

  // Stage 0: decode the request.
  logic [DW-1:0] br [5];
  logic [DW-1:0] bq [5];
  logic [DW-1:0] dv_q [4];
  logic f_band [5];
  logic f_zero [5];
  logic f_sat [5];
  logic [PW-1:0] f_t [5];
  logic [gscl_pkg::TOT_W-1:0] tot_m1;

  assign tot_m1 = req.band_total - 1'b1;

  always_ff @(posedge clk) begin
    if (en) begin
      f_band[0] <= req.kind;
      f_zero[0] <= req.band_total <= gscl_pkg::TOT_W'(1);
      f_sat[0] <= gscl_pkg::TOT_W'(req.band_num) >= tot_m1;
      f_t[0] <= (req.position > gscl_pkg::ONE_Q15) ? gscl_pkg::ONE_Q15 : req.position;
      dv_q[0] <= DW'(tot_m1);
      br[0] <= DW'(req.band_num);
      bq[0] <= '0;
    end
  end

  // Stages 1 to 4: band position division.
  for (genvar k = 0; k < 4; k++) begin : g_band_div
    logic [DW-1:0] r_n;
    logic [DW-1:0] q_n;
    gscl_div_step u_div (
      .rem_in(br[k]), .divisor(dv_q[k]), .quo_in(bq[k]), .rem_out(r_n), .quo_out(q_n)
    );
    always_ff @(posedge clk) begin
      if (en) begin
        br[k+1] <= r_n;
        bq[k+1] <= q_n;
        f_band[k+1] <= f_band[k];
        f_zero[k+1] <= f_zero[k];
        f_sat[k+1] <= f_sat[k];
        f_t[k+1] <= f_t[k];
      end
    end
    if (k < 3) begin : g_dv
      always_ff @(posedge clk) begin
        if (en) begin
          dv_q[k+1] <= dv_q[k];
        end
      end
    end
  end

  // Stage 5: final position.
  logic [PW-1:0] t_q;
  always_ff @(posedge clk) begin
    if (en) begin
      if (!f_band[4]) begin
        t_q <= f_t[4];
      end else if (f_zero[4]) begin
        t_q <= '0;
      end else if (f_sat[4]) begin
        t_q <= gscl_pkg::ONE_Q15;
      end else begin
        t_q <= {1'b0, bq[4][PW-1:1]};
      end
    end
  end

  // Stage 6: bracket search.
  logic [gscl_pkg::COUNT_W-1:0] n_use;
  logic [gscl_pkg::COUNT_W-1:0] n_last;
  logic [PW-1:0] last_p;
  logic [CW-1:0] last_c;
  logic hit;
  logic [PW-1:0] h_p0;
  logic [PW-1:0] h_p1;
  logic [CW-1:0] h_c0;
  logic [CW-1:0] h_c1;
  logic [CW-1:0] sel_c0_n;
  logic [CW-1:0] sel_c1_n;
  logic [PW-1:0] sel_num_n;
  logic [PW-1:0] sel_span_n;

  always_comb begin
    n_use = (stop_count < gscl_pkg::MIN_COUNT) ? gscl_pkg::MIN_COUNT : stop_count;
    n_last = n_use - 1'b1;
    last_p = stops[0][gscl_pkg::STOP_W-1:CW];
    last_c = stops[0][CW-1:0];
    for (int j = 0; j < gscl_pkg::MAX_STOPS; j++) begin
      if (gscl_pkg::COUNT_W'(j) == n_last) begin
        last_p = stops[j][gscl_pkg::STOP_W-1:CW];
        last_c = stops[j][CW-1:0];
      end
    end
    hit = 1'b0;
    h_p0 = '0;
    h_p1 = '0;
    h_c0 = '0;
    h_c1 = '0;
    for (int j = gscl_pkg::MAX_STOPS - 2; j >= 0; j--) begin
      if (gscl_pkg::COUNT_W'(j) < n_last && stops[j][gscl_pkg::STOP_W-1:CW] <= t_q &&
          t_q <= stops[j+1][gscl_pkg::STOP_W-1:CW]) begin
        hit = 1'b1;
        h_p0 = stops[j][gscl_pkg::STOP_W-1:CW];
        h_p1 = stops[j+1][gscl_pkg::STOP_W-1:CW];
        h_c0 = stops[j][CW-1:0];
        h_c1 = stops[j+1][CW-1:0];
      end
    end
    sel_num_n = '0;
    sel_span_n = gscl_pkg::NARROW_SPAN + 1'b1;
    if (t_q <= stops[0][gscl_pkg::STOP_W-1:CW]) begin
      sel_c0_n = stops[0][CW-1:0];
      sel_c1_n = stops[0][CW-1:0];
    end else if (t_q >= last_p || !hit) begin
      sel_c0_n = last_c;
      sel_c1_n = last_c;
    end else if (h_p1 - h_p0 <= gscl_pkg::NARROW_SPAN) begin
      sel_c0_n = h_c0;
      sel_c1_n = h_c0;
    end else begin
      sel_c0_n = h_c0;
      sel_c1_n = h_c1;
      sel_num_n = t_q - h_p0;
      sel_span_n = h_p1 - h_p0;
    end
  end

  logic [CW-1:0] sel_c0;
  logic [CW-1:0] sel_c1;
  logic [PW-1:0] sel_num;
  logic [PW-1:0] sel_span;
  always_ff @(posedge clk) begin
    if (en) begin
      sel_c0 <= sel_c0_n;
      sel_c1 <= sel_c1_n;
      sel_num <= sel_num_n;
      sel_span <= sel_span_n;
    end
  end

  // Stages 7 to 10: relative position division.
  logic [DW-1:0] rr [4];
  logic [DW-1:0] rq [4];
  logic [DW-1:0] rs_q [3];
  logic [CW-1:0] cc0 [7];
  logic [CW-1:0] cc1 [7];
  logic [DW-1:0] num_x;
  logic [DW-1:0] span_x;
  logic [DW-1:0] r_int;
  logic [DW-1:0] q_int;
  logic [DW-1:0] r0_n;
  logic [DW-1:0] q0_n;

  always_comb begin
    num_x = DW'(sel_num);
    span_x = DW'(sel_span);
    if (num_x >= span_x) begin
      r_int = num_x - span_x;
      q_int = DW'(1);
    end else begin
      r_int = num_x;
      q_int = '0;
    end
  end

  gscl_div_step u_rel0 (
    .rem_in(r_int), .divisor(span_x), .quo_in(q_int), .rem_out(r0_n), .quo_out(q0_n)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      rr[0] <= r0_n;
      rq[0] <= q0_n;
      rs_q[0] <= span_x;
      cc0[0] <= sel_c0;
      cc1[0] <= sel_c1;
    end
  end

  for (genvar k = 1; k < 4; k++) begin : g_rel_div
    logic [DW-1:0] r_n;
    logic [DW-1:0] q_n;
    gscl_div_step u_div (
      .rem_in(rr[k-1]), .divisor(rs_q[k-1]), .quo_in(rq[k-1]), .rem_out(r_n), .quo_out(q_n)
    );
    always_ff @(posedge clk) begin
      if (en) begin
        rr[k] <= r_n;
        rq[k] <= q_n;
      end
    end
    if (k < 3) begin : g_span
      always_ff @(posedge clk) begin
        if (en) begin
          rs_q[k] <= rs_q[k-1];
        end
      end
    end
  end

  for (genvar k = 1; k < 7; k++) begin : g_color
    always_ff @(posedge clk) begin
      if (en) begin
        cc0[k] <= cc0[k-1];
        cc1[k] <= cc1[k-1];
      end
    end
  end

  // Stages 11 to 13: smoothstep blend weight.
  logic [2*DW-1:0] rel2;
  logic [DW:0] kq;
  logic [2*DW+1:0] ph;
  logic [2*DW+1:0] pl;
  logic [DW-1:0] s_q;
  logic [2*DW+1+DW:0] s_sum;

  assign s_sum = {ph, {DW{1'b0}}} + (2*DW+2+DW)'(pl);

  always_ff @(posedge clk) begin
    if (en) begin
      rel2 <= rq[3] * rq[3];
      kq <= (DW+1)'(196608) - {rq[3], 1'b0};
      ph <= rel2[2*DW-1:DW] * kq;
      pl <= rel2[DW-1:0] * kq;
      s_q <= s_sum[DW+31:32];
    end
  end

  // Stage 14: channel products. Stage 15: rounding and output.
  logic [DW-1:0] w0;
  logic [DW+7:0] pa [4];
  logic [DW+7:0] pb [4];
  logic [7:0] col [4];

  assign w0 = DW'(65536) - s_q;

  for (genvar c = 0; c < 4; c++) begin : g_chan
    logic [DW+7:0] acc;
    assign acc = pa[c] + pb[c] + (DW+8)'(32768);
    always_ff @(posedge clk) begin
      if (en) begin
        pa[c] <= cc0[6][8*c+7:8*c] * w0;
        pb[c] <= cc1[6][8*c+7:8*c] * s_q;
        col[c] <= acc[23:16];
      end
    end
  end

  assign rsp.valid = vld[gscl_pkg::NSTAGE-1];
  assign rsp.red = col[3];
  assign rsp.green = col[2];
  assign rsp.blue = col[1];
  assign rsp.alpha = col[0];

  a_stall_hold: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    vld[gscl_pkg::NSTAGE-2] && en |=> rsp.valid)
    else $error("transaction lost before the output register");
  a_span: assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> sel_span > gscl_pkg::NARROW_SPAN)
    else $error("narrow span reached the divider");
  a_rel: assert property (@(posedge clk) disable iff (rst)
    vld[10] |-> rq[3] <= DW'(65536))
    else $error("relative position above one");

endmodule
